// ----- sv/luc_pkg.sv -----
// Shared constants, types and helpers for the least-used candidate store.
`default_nettype none
package luc_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = $clog2(CAPACITY + 1);
  localparam int REF_W    = 32;
  localparam int CNT_W    = 32;
  localparam int STEPS    = $clog2(CAPACITY);

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_BWD,
    ST_FRONT,
    ST_SEARCH,
    ST_SWAP,
    ST_SWAP_WR,
    ST_RESP
  } luc_state_e;

  // search bounds handed from one cell to the next
  typedef struct packed {
    logic             go;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } luc_link_t;

  // read request of one cell toward the count memory
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } luc_rdreq_t;

  // physical slot of logical position pos
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                input logic [POS_W-1:0] pos);
    logic [POS_W:0] sum;
    sum = {{(POS_W + 1 - IDX_W){1'b0}}, front} + {1'b0, pos};
    if (sum >= (POS_W + 1)'(CAPACITY)) begin
      sum = sum - (POS_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] mid_of(input logic [POS_W-1:0] lo,
                                               input logic [POS_W-1:0] hi);
    logic [POS_W-1:0] span;
    span = hi - lo;
    return lo + (span >> 1);
  endfunction

endpackage
`default_nettype wire

// ----- sv/luc_search_cell.sv -----
// One step of the binary search: read the middle entry, then narrow the bounds.
`default_nettype none
module luc_search_cell
  import luc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire luc_link_t        link_i,
  input  wire logic [IDX_W-1:0] front_i,
  input  wire logic [CNT_W-1:0] newc_i,
  input  wire logic [CNT_W-1:0] rd_count_i,
  output luc_rdreq_t            rd_req_o,
  output luc_link_t             link_o
);

  logic             rd_q, cmp_q;
  logic [POS_W-1:0] lo_q, hi_q;
  logic [POS_W-1:0] mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      cmp_q <= 1'b0;
    end else begin
      rd_q  <= link_i.go;
      cmp_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_i.go) begin
      lo_q <= link_i.lo;
      hi_q <= link_i.hi;
    end
  end

  assign mid = mid_of(lo_q, hi_q);

  always_comb begin
    rd_req_o.en   = rd_q;
    rd_req_o.addr = slot_of(front_i, mid);
    link_o.go     = cmp_q;
    link_o.lo     = lo_q;
    link_o.hi     = hi_q;
    // narrow only while the range is open
    if (lo_q < hi_q) begin
      if (rd_count_i < newc_i) begin
        link_o.lo = mid + POS_W'(1);
      end else begin
        link_o.hi = mid;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/least_used_candidate_store_unit.sv -----
// Top level: candidate store memory, request sequencer and search cell chain.
//
//   channel  | handshake            | words
//   ---------+----------------------+-----------------------------------------------
//   request  | start, busy          | req_type_i, fwd_valid_i, fwd_ref_i, bwd_valid_i,
//            |                      | bwd_ref_i
//   result   | done_o (one cycle)   | status_o, taken_ref_o, taken_count_o, fill_level_o
//
// An add pushes the forward word, then the backward word, then gives its result; a take on
// an empty store goes straight to the result, and any other take reads and bumps the front,
// searches, and swaps the taken entry when needed. The search is a chain of STEPS cells
// sharing the single read port of the entry memory. One request is in flight at a time;
// busy stays high until the result cycle ends. Reset empties the store at once.
`default_nettype none
module least_used_candidate_store_unit
  import luc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             req_type_i,
  input  wire logic             fwd_valid_i,
  input  wire logic [REF_W-1:0] fwd_ref_i,
  input  wire logic             bwd_valid_i,
  input  wire logic [REF_W-1:0] bwd_ref_i,
  output logic                  done_o,
  output logic                  status_o,
  output logic [REF_W-1:0]      taken_ref_o,
  output logic [CNT_W-1:0]      taken_count_o,
  output logic [POS_W-1:0]      fill_level_o
);

  logic [REF_W-1:0] handle_mem [CAPACITY];
  logic [CNT_W-1:0] count_mem  [CAPACITY];

  luc_state_e       state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [POS_W-1:0] total_q, total_d;

  logic             bwd_valid_q;
  logic [REF_W-1:0] bwd_ref_q;
  logic             status_q, status_d;
  logic [REF_W-1:0] tref_q, tref_d;
  logic [CNT_W-1:0] newc_q, newc_d;
  logic [IDX_W-1:0] swap_slot_q, swap_slot_d;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [REF_W-1:0] wr_ref;
  logic [CNT_W-1:0] wr_count;
  logic [IDX_W-1:0] fsm_rd_addr, rd_addr;
  logic [REF_W-1:0] rd_ref_q;
  logic [CNT_W-1:0] rd_count_q;

  logic             accept;
  logic [CNT_W-1:0] inc_count;
  logic [IDX_W-1:0] push_slot;

  luc_link_t        link [STEPS+1];
  luc_rdreq_t       cell_req [STEPS];
  logic             cell_rd_en;
  logic [IDX_W-1:0] cell_rd_addr;

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      handle_mem[wr_addr] <= wr_ref;
      count_mem[wr_addr]  <= wr_count;
    end
    rd_ref_q   <= handle_mem[rd_addr];
    rd_count_q <= count_mem[rd_addr];
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    luc_search_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .link_i     (link[k]),
      .front_i    (front_q),
      .newc_i     (newc_q),
      .rd_count_i (rd_count_q),
      .rd_req_o   (cell_req[k]),
      .link_o     (link[k+1])
    );
  end

  // at most one cell reads in any cycle
  always_comb begin
    cell_rd_en   = 1'b0;
    cell_rd_addr = '0;
    for (int k = 0; k < STEPS; k++) begin
      cell_rd_en   = cell_rd_en | cell_req[k].en;
      cell_rd_addr = cell_rd_addr | (cell_req[k].en ? cell_req[k].addr : '0);
    end
  end

  assign rd_addr   = cell_rd_en ? cell_rd_addr : fsm_rd_addr;
  assign accept    = start && !busy;
  assign inc_count = (rd_count_q == '1) ? rd_count_q : rd_count_q + CNT_W'(1);
  assign push_slot = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      front_q <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bwd_valid_q <= bwd_valid_i;
      bwd_ref_q   <= bwd_ref_i;
    end
    status_q    <= status_d;
    tref_q      <= tref_d;
    newc_q      <= newc_d;
    swap_slot_q <= swap_slot_d;
  end

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    total_d     = total_q;
    status_d    = status_q;
    tref_d      = tref_q;
    newc_d      = newc_q;
    swap_slot_d = swap_slot_q;
    wr_en       = 1'b0;
    wr_addr     = push_slot;
    wr_ref      = fwd_ref_i;
    wr_count    = '0;
    fsm_rd_addr = front_q;
    link[0]     = '{go: 1'b0, lo: POS_W'(1), hi: total_q};
    busy        = (state_q != ST_IDLE);
    done_o      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = STATUS_OK;
          tref_d   = '0;
          newc_d   = '0;
          if (req_type_i == REQ_ADD) begin
            // push the forward word now, the backward one next cycle
            if (fwd_valid_i) begin
              wr_en   = 1'b1;
              front_d = push_slot;
              if (total_q < POS_W'(CAPACITY)) begin
                total_d = total_q + POS_W'(1);
              end
            end
            state_d = ST_ADD_BWD;
          end else if (total_q == '0) begin
            status_d = STATUS_EMPTY;
            state_d  = ST_RESP;
          end else begin
            // front read issued this cycle
            state_d = ST_FRONT;
          end
        end
      end

      ST_ADD_BWD: begin
        if (bwd_valid_q) begin
          wr_en   = 1'b1;
          wr_ref  = bwd_ref_q;
          front_d = push_slot;
          if (total_q < POS_W'(CAPACITY)) begin
            total_d = total_q + POS_W'(1);
          end
        end
        state_d = ST_RESP;
      end

      ST_FRONT: begin
        tref_d      = rd_ref_q;
        newc_d      = inc_count;
        wr_en       = 1'b1;
        wr_addr     = front_q;
        wr_ref      = rd_ref_q;
        wr_count    = inc_count;
        link[0].go  = 1'b1;
        state_d     = ST_SEARCH;
      end

      ST_SEARCH: begin
        if (link[STEPS].go) begin
          if (link[STEPS].lo > POS_W'(1)) begin
            swap_slot_d = slot_of(front_q, link[STEPS].lo - POS_W'(1));
            fsm_rd_addr = swap_slot_d;
            state_d     = ST_SWAP;
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      ST_SWAP: begin
        // lesser entry moves to the front
        wr_en    = 1'b1;
        wr_addr  = front_q;
        wr_ref   = rd_ref_q;
        wr_count = rd_count_q;
        state_d  = ST_SWAP_WR;
      end

      ST_SWAP_WR: begin
        wr_en    = 1'b1;
        wr_addr  = swap_slot_q;
        wr_ref   = tref_q;
        wr_count = newc_q;
        state_d  = ST_RESP;
      end

      ST_RESP: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign status_o      = status_q;
  assign taken_ref_o   = tref_q;
  assign taken_count_o = newc_q;
  assign fill_level_o  = total_q;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the least-used candidate store: directed table, then random requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import luc_pkg::*;

  localparam int STALL_LIMIT      = 3000;
  localparam int RANDOM_PER_PHASE = 570;
  localparam int DRAIN_CYCLES     = 40;
  localparam int N_DIRECTED       = 20;

  typedef struct packed {
    logic             status;
    logic [REF_W-1:0] handle;
    logic [CNT_W-1:0] uses;
    logic [POS_W-1:0] fill;
  } store_reply_t;

  typedef struct packed {
    logic         rtype;
    logic         fvalid;
    logic [31:0]  fref;
    logic         bvalid;
    logic [31:0]  bref;
    logic         typed;
    store_reply_t reply;
  } directed_row_t;

  // rows with typed = 1 carry a hand-worked reply, the rest use the mirror
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{REQ_TAKE, 1'b0, 32'h0, 1'b0, 32'h0, 1'b1, '{STATUS_EMPTY, 32'h0, 32'd0, 11'd0}},
    '{REQ_TAKE, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
      '{STATUS_EMPTY, 32'h0, 32'd0, 11'd0}},
    '{REQ_ADD, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1,
      '{STATUS_OK, 32'h0, 32'd0, 11'd0}},
    '{REQ_ADD, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1, '{STATUS_OK, 32'h0, 32'd0, 11'd1}},
    '{REQ_TAKE, 1'b0, 32'h0, 1'b0, 32'h0, 1'b1,
      '{STATUS_OK, 32'hFFFF_FFFF, 32'd1, 11'd1}},
    '{REQ_TAKE, 1'b0, 32'h0, 1'b0, 32'h0, 1'b1,
      '{STATUS_OK, 32'hFFFF_FFFF, 32'd2, 11'd1}},
    '{REQ_ADD, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1, '{STATUS_OK, 32'h0, 32'd0, 11'd2}},
    '{REQ_TAKE, 1'b0, 32'h0, 1'b0, 32'h0, 1'b1, '{STATUS_OK, 32'h0, 32'd1, 11'd2}},
    '{REQ_TAKE, 1'b0, 32'h0, 1'b0, 32'h0, 1'b1, '{STATUS_OK, 32'h0, 32'd2, 11'd2}},
    '{REQ_TAKE, 1'b0, 32'h0, 1'b0, 32'h0, 1'b1, '{STATUS_OK, 32'h0, 32'd3, 11'd2}},
    '{REQ_ADD, 1'b1, 32'hA5A5_A5A5, 1'b1, 32'h5A5A_5A5A, 1'b1,
      '{STATUS_OK, 32'h0, 32'd0, 11'd4}},
    '{REQ_TAKE, 1'b0, 32'h0, 1'b0, 32'h0, 1'b1,
      '{STATUS_OK, 32'h5A5A_5A5A, 32'd1, 11'd4}},
    '{REQ_TAKE, 1'b0, 32'h0, 1'b0, 32'h0, 1'b1,
      '{STATUS_OK, 32'hA5A5_A5A5, 32'd1, 11'd4}},
    '{REQ_TAKE, 1'b0, 32'h0, 1'b0, 32'h0, 1'b1,
      '{STATUS_OK, 32'hA5A5_A5A5, 32'd2, 11'd4}},
    '{REQ_ADD, 1'b1, 32'h8000_0000, 1'b1, 32'h0000_0001, 1'b0,
      '{STATUS_OK, 32'h0, 32'd0, 11'd0}},
    '{REQ_TAKE, 1'b1, 32'h1234_5678, 1'b0, 32'h0, 1'b0, '{STATUS_OK, 32'h0, 32'd0, 11'd0}},
    '{REQ_TAKE, 1'b0, 32'h0, 1'b1, 32'h8765_4321, 1'b0, '{STATUS_OK, 32'h0, 32'd0, 11'd0}},
    '{REQ_ADD, 1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, '{STATUS_OK, 32'h0, 32'd0, 11'd0}},
    '{REQ_TAKE, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0, '{STATUS_OK, 32'h0, 32'd0, 11'd0}},
    '{REQ_TAKE, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0, '{STATUS_OK, 32'h0, 32'd0, 11'd0}}
  };

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             req_type_i  = REQ_ADD;
  logic             fwd_valid_i = 1'b0;
  logic [REF_W-1:0] fwd_ref_i   = '0;
  logic             bwd_valid_i = 1'b0;
  logic [REF_W-1:0] bwd_ref_i   = '0;
  logic             busy;
  logic             done_o;
  logic             status_o;
  logic [REF_W-1:0] taken_ref_o;
  logic [CNT_W-1:0] taken_count_o;
  logic [POS_W-1:0] fill_level_o;

  // mirror of the store contents, logical position i at (front + i) mod CAPACITY
  logic [REF_W-1:0] mirror_handle [CAPACITY];
  logic [CNT_W-1:0] mirror_uses   [CAPACITY];
  int               mirror_front = 0;
  int               mirror_total = 0;

  store_reply_t pending_replies [$];
  int           errors          = 0;
  int           stall_cycles    = 0;
  int           sender_idle_pct = 0;

  least_used_candidate_store_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .fwd_valid_i   (fwd_valid_i),
    .fwd_ref_i     (fwd_ref_i),
    .bwd_valid_i   (bwd_valid_i),
    .bwd_ref_i     (bwd_ref_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .taken_ref_o   (taken_ref_o),
    .taken_count_o (taken_count_o),
    .fill_level_o  (fill_level_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int slot_at(input int pos);
    return (mirror_front + pos) % CAPACITY;
  endfunction

  // push to the front, dropping the oldest entry once full
  function automatic void push_candidate(input logic [REF_W-1:0] handle);
    mirror_front = (mirror_front + CAPACITY - 1) % CAPACITY;
    mirror_handle[mirror_front] = handle;
    mirror_uses[mirror_front]   = '0;
    if (mirror_total < CAPACITY) begin
      mirror_total++;
    end
  endfunction

  function automatic store_reply_t predict_request(input logic             rtype,
                                                   input logic             fvalid,
                                                   input logic [REF_W-1:0] fref,
                                                   input logic             bvalid,
                                                   input logic [REF_W-1:0] bref);
    store_reply_t     r;
    int               lo;
    int               hi;
    int               mid;
    int               front_slot;
    int               swap_slot;
    logic [CNT_W-1:0] bumped;
    logic [REF_W-1:0] held_handle;
    logic [CNT_W-1:0] held_uses;
    r        = '0;
    r.status = STATUS_OK;
    if (rtype == REQ_ADD) begin
      if (fvalid) push_candidate(fref);
      if (bvalid) push_candidate(bref);
    end else if (mirror_total == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      front_slot = mirror_front;
      bumped     = mirror_uses[front_slot];
      if (bumped != '1) bumped++;
      mirror_uses[front_slot] = bumped;
      // find the first position behind the front not below the new count
      lo = 1;
      hi = mirror_total;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (mirror_uses[slot_at(mid)] < bumped) lo = mid + 1;
        else hi = mid;
      end
      r.handle = mirror_handle[front_slot];
      r.uses   = bumped;
      if (lo > 1) begin
        swap_slot                 = slot_at(lo - 1);
        held_handle               = mirror_handle[swap_slot];
        held_uses                 = mirror_uses[swap_slot];
        mirror_handle[swap_slot]  = mirror_handle[front_slot];
        mirror_uses[swap_slot]    = mirror_uses[front_slot];
        mirror_handle[front_slot] = held_handle;
        mirror_uses[front_slot]   = held_uses;
      end
    end
    r.fill = POS_W'(mirror_total);
    return r;
  endfunction

  function automatic logic [REF_W-1:0] random_handle();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return REF_W'($urandom());
    endcase
  endfunction

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_request(input logic             rtype,
                              input logic             fvalid,
                              input logic [REF_W-1:0] fref,
                              input logic             bvalid,
                              input logic [REF_W-1:0] bref,
                              input logic             typed,
                              input store_reply_t     typed_reply);
    store_reply_t predicted;
    int           gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i  = rtype;
    fwd_valid_i = fvalid;
    fwd_ref_i   = fref;
    bwd_valid_i = bvalid;
    bwd_ref_i   = bref;
    start       = 1'b1;
    do @(posedge clk_i); while (busy);
    predicted = predict_request(rtype, fvalid, fref, bvalid, bref);
    pending_replies.push_back(typed ? typed_reply : predicted);
    @(negedge clk_i);
  endtask

  // hold the sender until every reply is back
  task automatic drain_replies();
    start = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
  endtask

  function automatic bit field_differs(input string       name,
                                       input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i) begin : reply_check
    store_reply_t got;
    store_reply_t want;
    bit           bad;
    if (rst_ni && done_o) begin
      got = '{status_o, taken_ref_o, taken_count_o, fill_level_o};
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with none expected, actual status %0d ref 0x%08h count %0d fill %0d",
                 $time, got.status, got.handle, got.uses, got.fill);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        bad  = field_differs("status", 32'(want.status), 32'(got.status));
        bad |= field_differs("taken_ref", want.handle, got.handle);
        bad |= field_differs("taken_count", want.uses, got.uses);
        bad |= field_differs("fill_level", 32'(want.fill), 32'(got.fill));
        if (bad) errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    logic rtype;
    int   add_pct;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    sender_idle_pct = 11;
    foreach (DIRECTED_ROWS[i]) begin
      send_request(DIRECTED_ROWS[i].rtype, DIRECTED_ROWS[i].fvalid, DIRECTED_ROWS[i].fref,
                   DIRECTED_ROWS[i].bvalid, DIRECTED_ROWS[i].bref, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].reply);
    end
    drain_replies();

    // add-heavy phases first so the store fills and starts dropping old entries
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 63 : 0;
      add_pct         = (phase == 0) ? 75 : (phase == 1) ? 60 : 35;
      repeat (RANDOM_PER_PHASE) begin
        rtype = ($urandom_range(99) < add_pct) ? REQ_ADD : REQ_TAKE;
        send_request(rtype, $urandom_range(9) != 0, random_handle(),
                     $urandom_range(9) != 0, random_handle(), 1'b0, '0);
      end
      drain_replies();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/luc_pkg.sv
sv/luc_search_cell.sv
sv/least_used_candidate_store_unit.sv
bench/tb_top.sv
